// ===== design/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on aclk; CSD_ASSERT is off during reset
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising edge outside reset
`define CSD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// same, but also checked while reset is active
`define CSD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

// ===== design/csd_pkg.sv =====
// ---------------------------------------------------------------------------
// csd_pkg
// Codes, widths and denomination tables of the change stock dispenser
// ---------------------------------------------------------------------------
package csd_pkg;

    localparam int AMT_W    = 27;
    localparam int DENOM_W  = 14;
    localparam int SLOT_W   = 4;
    localparam int QTY_W    = 12;
    localparam int MODE_W   = 3;
    localparam int STAT_W   = 3;
    localparam int HOUR_W   = 5;
    localparam int START_W  = 7;

    localparam logic [AMT_W-1:0]  AMT_MAX          = '1;
    localparam logic [AMT_W-1:0]  THRESH_RESET     = 27'd2000;
    localparam logic [HOUR_W-1:0] HOURS_MAX        = 5'd31;
    localparam logic [HOUR_W-1:0] HOURS_RESET      = 5'd24;

    // operation codes
    localparam logic [MODE_W-1:0] MODE_ACCEPT   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_DISPENSE = 3'd1;
    localparam logic [MODE_W-1:0] MODE_CHECK    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_ADD      = 3'd3;
    localparam logic [MODE_W-1:0] MODE_REFILL   = 3'd4;
    localparam logic [MODE_W-1:0] MODE_HOUR     = 3'd5;

    // result status codes
    localparam logic [STAT_W-1:0] ST_DONE      = 3'd0;
    localparam logic [STAT_W-1:0] ST_ITEM      = 3'd1;
    localparam logic [STAT_W-1:0] ST_CANNOT    = 3'd2;
    localparam logic [STAT_W-1:0] ST_TOO_SOON  = 3'd3;
    localparam logic [STAT_W-1:0] ST_NO_REFILL = 3'd4;
    localparam logic [STAT_W-1:0] ST_CHECK_OK  = 3'd5;

    // configuration register indexes
    localparam logic CFG_LOW_THRESHOLD   = 1'b0;
    localparam logic CFG_REFILL_INTERVAL = 1'b1;

    // denomination in cents of a slot, zero beyond the tenth
    function automatic logic [DENOM_W-1:0] denom_of(input logic [SLOT_W-1:0] s);
        case (s)
            4'd0:    denom_of = 14'd10000;
            4'd1:    denom_of = 14'd5000;
            4'd2:    denom_of = 14'd2000;
            4'd3:    denom_of = 14'd1000;
            4'd4:    denom_of = 14'd500;
            4'd5:    denom_of = 14'd100;
            4'd6:    denom_of = 14'd25;
            4'd7:    denom_of = 14'd10;
            4'd8:    denom_of = 14'd5;
            4'd9:    denom_of = 14'd1;
            default: denom_of = 14'd0;
        endcase
    endfunction

    // starting and refill piece count of a slot
    function automatic logic [START_W-1:0] start_count(input logic [SLOT_W-1:0] s);
        case (s)
            4'd0:    start_count = 7'd0;
            4'd1:    start_count = 7'd2;
            4'd2:    start_count = 7'd2;
            4'd3:    start_count = 7'd4;
            4'd4:    start_count = 7'd2;
            4'd5:    start_count = 7'd6;
            4'd6:    start_count = 7'd6;
            4'd7:    start_count = 7'd10;
            4'd8:    start_count = 7'd10;
            4'd9:    start_count = 7'd100;
            default: start_count = 7'd0;
        endcase
    endfunction

endpackage

// ===== design/csd_qsearch.sv =====
// ---------------------------------------------------------------------------
// csd_qsearch
// Bit-serial capped quotient: largest q <= cap with q * divisor <= rem,
// one quotient bit per cycle, also returns the product q * divisor
// ---------------------------------------------------------------------------
module csd_qsearch #(
    parameter int QW = 12,
    parameter int DW = 14,
    parameter int RW = 27
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [RW-1:0] rem,
    input  logic [DW-1:0] divisor,
    input  logic [QW-1:0] cap,
    output logic          busy,
    output logic          done,
    output logic [QW-1:0] q,
    output logic [RW-1:0] prod
);

    localparam int BW = (QW > 1) ? $clog2(QW) : 1;
    localparam int PW = ((RW > DW + QW) ? RW : DW + QW) + 1;

    logic          busy_reg;
    logic          done_reg;
    logic [BW-1:0] bit_reg;
    logic [QW-1:0] q_reg;
    logic [RW-1:0] prod_reg;

    logic [QW-1:0] try_q;
    logic [PW-1:0] try_p;
    logic          take;

    // candidate with the current bit set
    always_comb begin
        try_q = q_reg | (QW'(1) << bit_reg);
        try_p = PW'(prod_reg) + (PW'(divisor) << bit_reg);
        take  = (divisor != '0) && (try_q <= cap) && (try_p <= PW'(rem));
    end

    // one quotient bit per cycle, msb first
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                bit_reg  <= BW'(QW - 1);
                q_reg    <= '0;
                prod_reg <= '0;
            end else if (busy_reg) begin
                if (take) begin
                    q_reg    <= try_q;
                    prod_reg <= try_p[RW-1:0];
                end
                if (bit_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    bit_reg <= bit_reg - 1'b1;
                end
            end
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign q    = q_reg;
    assign prod = prod_reg;

endmodule

// ===== design/change_stock_dispenser.sv =====
// Steps per item, acceptance to ready again, quotient width QW = max(12,COUNT_BITS): accept
// runs one quotient search on its slot if valid; tick and early replenish go straight on, add
// updates its slot; check and failed dispense run a quotient search per slot; dispense then takes
// the change out slot by slot; replenish refills slot by slot; then all walk the balance and emit
// results; one item at a time, the last result shows in the same cycle as ready; a held result stalls the sequencer.
// Reset (aresetn low, synchronous) loads the starting stock, zero due, 24 hours.
// ---------------------------------------------------------------------------
// change_stock_dispenser
// Note and coin stock with greedy change-making over ten denominations
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module change_stock_dispenser import csd_pkg::*; #(
    parameter int NUM_SLOTS  = 10,
    parameter int COUNT_BITS = 12
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [AMT_W-1:0]   cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [MODE_W-1:0]  s_mode,
    input  logic [SLOT_W-1:0]  s_slot,
    input  logic [QTY_W-1:0]   s_quantity,
    input  logic [AMT_W-1:0]   s_amount_cents,
    input  logic               s_first,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [STAT_W-1:0]  m_status,
    output logic [SLOT_W-1:0]  m_slot_out,
    output logic [QTY_W-1:0]   m_count_out,
    output logic [AMT_W-1:0]   m_due_left,
    output logic [AMT_W-1:0]   m_total_balance,
    output logic               m_is_low,
    output logic               m_last
);

    localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int QW = (COUNT_BITS > QTY_W) ? COUNT_BITS : QTY_W;
    localparam int SW = QW + 1;
    localparam int PBW = DENOM_W + COUNT_BITS;
    localparam int AW = ((PBW > AMT_W + 1) ? PBW : AMT_W + 1) + 1;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [IW-1:0] LAST_IDX = IW'(NUM_SLOTS - 1);

    typedef enum logic [3:0] {
        S_IDLE, S_DIV, S_TDONE, S_COMMIT, S_ADD, S_REFILL, S_BAL, S_OUT, S_EMIT
    } state_t;

    state_t                state_reg;
    logic [IW-1:0]         idx_reg;
    logic [IW-1:0]         lastnz_reg;
    logic                  any_reg;
    logic                  emit_reg;
    logic [MODE_W-1:0]     mode_reg;
    logic [SLOT_W-1:0]     slot_reg;
    logic [QTY_W-1:0]      qty_reg;
    logic [AMT_W-1:0]      rem_reg;
    logic [AMT_W-1:0]      due_reg;
    logic [HOUR_W-1:0]     hours_reg;
    logic [AMT_W-1:0]      low_thr_reg;
    logic [HOUR_W-1:0]     interval_reg;
    logic [AMT_W-1:0]      bal_reg;
    logic [STAT_W-1:0]     res_status_reg;
    logic [SLOT_W-1:0]     res_slot_reg;
    logic [QTY_W-1:0]      res_count_reg;
    logic                  q_start_reg;
    logic [COUNT_BITS-1:0] stock_reg [NUM_SLOTS];
    logic [COUNT_BITS-1:0] taken_mem [NUM_SLOTS];

    logic                  m_valid_reg;
    logic [STAT_W-1:0]     m_status_reg;
    logic [SLOT_W-1:0]     m_slot_reg;
    logic [QTY_W-1:0]      m_count_reg;
    logic [AMT_W-1:0]      m_due_reg;
    logic [AMT_W-1:0]      m_bal_reg;
    logic                  m_low_reg;
    logic                  m_last_reg;

    logic                  q_busy;
    logic                  q_done;
    logic [QW-1:0]         q_val;
    logic [AMT_W-1:0]      q_prod;

    logic [COUNT_BITS-1:0] stock_cur;
    logic [COUNT_BITS-1:0] taken_cur;
    logic [COUNT_BITS-1:0] target_cur;
    logic [DENOM_W-1:0]    denom_cur;
    logic [QW-1:0]         q_cap;
    logic [SW-1:0]         acc_sum;
    logic [SW-1:0]         add_sum;
    logic [COUNT_BITS-1:0] acc_sat;
    logic [COUNT_BITS-1:0] add_sat;
    logic [PBW-1:0]        bal_prod;
    logic [AW-1:0]         bal_sum;
    logic [AMT_W-1:0]      bal_next;
    logic [QW-1:0]         taken_wide;
    logic                  out_free;
    logic                  in_range;
    logic [AMT_W-1:0]      due_load;
    logic [AMT_W-1:0]      rem_after;

    // per-slot values at the walk index
    always_comb begin
        stock_cur  = stock_reg[idx_reg];
        taken_cur  = taken_mem[idx_reg];
        target_cur = COUNT_BITS'(start_count(SLOT_W'(idx_reg)));
        denom_cur  = denom_of(SLOT_W'(idx_reg));
        q_cap      = (mode_reg == MODE_ACCEPT) ? QW'(qty_reg) : QW'(stock_cur);
        taken_wide = QW'(taken_cur);
        // saturating adds for accept and add cash
        acc_sum    = SW'(stock_cur) + SW'(q_val);
        acc_sat    = (acc_sum > SW'(COUNT_MAX)) ? COUNT_MAX : acc_sum[COUNT_BITS-1:0];
        add_sum    = SW'(stock_cur) + SW'(qty_reg);
        add_sat    = (add_sum > SW'(COUNT_MAX)) ? COUNT_MAX : add_sum[COUNT_BITS-1:0];
        // balance step, sticky saturation at the field maximum
        bal_prod   = PBW'(denom_cur) * PBW'(stock_cur);
        bal_sum    = AW'(bal_reg) + AW'(bal_prod);
        bal_next   = (bal_sum > AW'(AMT_MAX)) ? AMT_MAX : bal_sum[AMT_W-1:0];
        rem_after  = rem_reg - q_prod;
        out_free   = !m_valid_reg || m_ready;
        in_range   = ({1'b0, s_slot} < (SLOT_W + 1)'(NUM_SLOTS));
        due_load   = s_first ? s_amount_cents : due_reg;
    end

    csd_qsearch #(
        .QW (QW),
        .DW (DENOM_W),
        .RW (AMT_W)
    ) u_qsearch (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (q_start_reg),
        .rem     (rem_reg),
        .divisor (denom_cur),
        .cap     (q_cap),
        .busy    (q_busy),
        .done    (q_done),
        .q       (q_val),
        .prod    (q_prod)
    );

    // sequencer, stock and result registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            due_reg      <= '0;
            hours_reg    <= HOURS_RESET;
            low_thr_reg  <= THRESH_RESET;
            interval_reg <= HOURS_RESET;
            q_start_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
            idx_reg      <= '0;
            any_reg      <= 1'b0;
            emit_reg     <= 1'b0;
            for (int s = 0; s < NUM_SLOTS; s++) begin
                stock_reg[s] <= COUNT_BITS'(start_count(SLOT_W'(s)));
            end
        end else begin
            q_start_reg <= 1'b0;
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end

            // configuration writes
            if (cfg_we) begin
                case (cfg_index)
                    CFG_LOW_THRESHOLD:   low_thr_reg  <= cfg_wdata;
                    CFG_REFILL_INTERVAL: interval_reg <= cfg_wdata[HOUR_W-1:0];
                    default: ;
                endcase
            end

            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        mode_reg       <= s_mode;
                        slot_reg       <= s_slot;
                        qty_reg        <= s_quantity;
                        res_status_reg <= ST_DONE;
                        res_slot_reg   <= '0;
                        res_count_reg  <= '0;
                        emit_reg       <= 1'b0;
                        bal_reg        <= '0;
                        idx_reg        <= '0;
                        any_reg        <= 1'b0;
                        case (s_mode)
                            MODE_ACCEPT: begin
                                due_reg      <= due_load;
                                res_slot_reg <= s_slot;
                                if (in_range && denom_of(s_slot) != '0) begin
                                    rem_reg     <= due_load;
                                    idx_reg     <= s_slot[IW-1:0];
                                    q_start_reg <= 1'b1;
                                    state_reg   <= S_DIV;
                                end else begin
                                    state_reg <= S_BAL;
                                end
                            end
                            MODE_DISPENSE, MODE_CHECK: begin
                                rem_reg     <= s_amount_cents;
                                q_start_reg <= 1'b1;
                                state_reg   <= S_DIV;
                            end
                            MODE_ADD: begin
                                res_slot_reg <= s_slot;
                                if (in_range) begin
                                    idx_reg   <= s_slot[IW-1:0];
                                    state_reg <= S_ADD;
                                end else begin
                                    state_reg <= S_BAL;
                                end
                            end
                            MODE_REFILL: begin
                                if (hours_reg < interval_reg) begin
                                    res_status_reg <= ST_TOO_SOON;
                                    state_reg      <= S_BAL;
                                end else begin
                                    state_reg <= S_REFILL;
                                end
                            end
                            MODE_HOUR: begin
                                if (hours_reg < HOURS_MAX) begin
                                    hours_reg <= hours_reg + 1'b1;
                                end
                                state_reg <= S_BAL;
                            end
                            default: ;
                        endcase
                    end
                end

                // wait for the quotient of the current slot
                S_DIV: begin
                    if (q_done) begin
                        if (mode_reg == MODE_ACCEPT) begin
                            due_reg            <= due_reg - q_prod;
                            stock_reg[idx_reg] <= acc_sat;
                            res_count_reg      <= q_val[QTY_W-1:0];
                            idx_reg            <= '0;
                            state_reg          <= S_BAL;
                        end else begin
                            taken_mem[idx_reg] <= q_val[COUNT_BITS-1:0];
                            rem_reg            <= rem_after;
                            if (idx_reg == LAST_IDX) begin
                                state_reg <= S_TDONE;
                            end else begin
                                idx_reg     <= idx_reg + 1'b1;
                                q_start_reg <= 1'b1;
                            end
                        end
                    end
                end

                // trial finished: exact change or not
                S_TDONE: begin
                    idx_reg <= '0;
                    if (mode_reg == MODE_CHECK) begin
                        res_status_reg <= (rem_reg == '0) ? ST_CHECK_OK : ST_CANNOT;
                        state_reg      <= S_BAL;
                    end else if (rem_reg != '0) begin
                        res_status_reg <= ST_CANNOT;
                        state_reg      <= S_BAL;
                    end else begin
                        state_reg <= S_COMMIT;
                    end
                end

                // take the change out of stock
                S_COMMIT: begin
                    stock_reg[idx_reg] <= stock_cur - taken_cur;
                    if (taken_cur != '0) begin
                        any_reg    <= 1'b1;
                        lastnz_reg <= idx_reg;
                    end
                    if (idx_reg == LAST_IDX) begin
                        emit_reg  <= any_reg || (taken_cur != '0);
                        idx_reg   <= '0;
                        state_reg <= S_BAL;
                    end else begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end

                S_ADD: begin
                    stock_reg[idx_reg] <= add_sat;
                    res_count_reg      <= QTY_W'(add_sat - stock_cur);
                    idx_reg            <= '0;
                    state_reg          <= S_BAL;
                end

                // refill each slot to its target, recording the increase
                S_REFILL: begin
                    if (stock_cur < target_cur) begin
                        taken_mem[idx_reg] <= target_cur - stock_cur;
                        stock_reg[idx_reg] <= target_cur;
                        any_reg            <= 1'b1;
                        lastnz_reg         <= idx_reg;
                    end else begin
                        taken_mem[idx_reg] <= '0;
                    end
                    if (idx_reg == LAST_IDX) begin
                        if (any_reg || (stock_cur < target_cur)) begin
                            hours_reg <= '0;
                            emit_reg  <= 1'b1;
                        end else begin
                            res_status_reg <= ST_NO_REFILL;
                        end
                        idx_reg   <= '0;
                        state_reg <= S_BAL;
                    end else begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end

                // balance walk, one slot per cycle
                S_BAL: begin
                    bal_reg <= bal_next;
                    if (idx_reg == LAST_IDX) begin
                        idx_reg   <= '0;
                        state_reg <= emit_reg ? S_EMIT : S_OUT;
                    end else begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end

                // single result
                S_OUT: begin
                    if (out_free) begin
                        m_valid_reg  <= 1'b1;
                        m_status_reg <= res_status_reg;
                        m_slot_reg   <= res_slot_reg;
                        m_count_reg  <= res_count_reg;
                        m_due_reg    <= due_reg;
                        m_bal_reg    <= bal_reg;
                        m_low_reg    <= (bal_reg < low_thr_reg);
                        m_last_reg   <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end

                // one result per slot with a nonzero count
                S_EMIT: begin
                    if (taken_cur == '0) begin
                        idx_reg <= idx_reg + 1'b1;
                    end else if (out_free) begin
                        m_valid_reg  <= 1'b1;
                        m_status_reg <= ST_ITEM;
                        m_slot_reg   <= SLOT_W'(idx_reg);
                        m_count_reg  <= taken_wide[QTY_W-1:0];
                        m_due_reg    <= due_reg;
                        m_bal_reg    <= bal_reg;
                        m_low_reg    <= (bal_reg < low_thr_reg);
                        m_last_reg   <= (idx_reg == lastnz_reg);
                        if (idx_reg == lastnz_reg) begin
                            state_reg <= S_IDLE;
                        end else begin
                            idx_reg <= idx_reg + 1'b1;
                        end
                    end
                end

                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_ready         = (state_reg == S_IDLE);
    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_slot_out      = m_slot_reg;
    assign m_count_out     = m_count_reg;
    assign m_due_left      = m_due_reg;
    assign m_total_balance = m_bal_reg;
    assign m_is_low        = m_low_reg;
    assign m_last          = m_last_reg;

    // quotient unit only runs under the divide state
    `CSD_ASSERT(a_qbusy_in_div, q_busy |-> (state_reg == S_DIV), "quotient unit busy outside divide")
    // a known operation takes the block busy on the next cycle
    `CSD_ASSERT(a_busy_after_accept, (s_valid && s_ready && s_mode <= MODE_HOUR) |=> !s_ready, "block still ready after an item")
    // counts are only carried by done and item results
    `CSD_ASSERT(a_count_status, (m_valid && m_status != ST_ITEM && m_status != ST_DONE) |-> (m_count_out == '0), "nonzero count on a status-only result")

endmodule

// ===== test/testbench.sv =====
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the change stock dispenser: a directed table of
// operations and a random run of cash sessions, all checked item by item
// against a behavioral model of the stock, under several idle patterns
// ---------------------------------------------------------------------------
module testbench;
    import csd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSLOT = 10;
    localparam int CYCLE_LIMIT = 900000;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [SLOT_W-1:0] slot;
        logic [QTY_W-1:0]  qty;
        logic [AMT_W-1:0]  amt;
        logic              first;
    } op_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [SLOT_W-1:0] slot;
        logic [QTY_W-1:0]  count;
        logic [AMT_W-1:0]  due;
        logic [AMT_W-1:0]  bal;
        logic              low;
        logic              last;
    } res_t;

    // directed rows: operation, typed-in status (or checked by model only)
    typedef struct {
        op_t               op;
        bit                has_stat;
        logic [STAT_W-1:0] stat;
    } row_t;

    logic aclk = 0;
    logic aresetn = 0;
    logic cfg_we = 0;
    logic cfg_index = 0;
    logic [AMT_W-1:0] cfg_wdata = 0;
    logic s_valid = 0;
    logic s_ready;
    logic [MODE_W-1:0] s_mode = 0;
    logic [SLOT_W-1:0] s_slot = 0;
    logic [QTY_W-1:0] s_quantity = 0;
    logic [AMT_W-1:0] s_amount_cents = 0;
    logic s_first = 0;
    logic m_valid;
    logic m_ready = 0;
    logic [STAT_W-1:0] m_status;
    logic [SLOT_W-1:0] m_slot_out;
    logic [QTY_W-1:0] m_count_out;
    logic [AMT_W-1:0] m_due_left;
    logic [AMT_W-1:0] m_total_balance;
    logic m_is_low;
    logic m_last;

    change_stock_dispenser dut (.*);

    always begin
        #4 aclk = 1;
        #4 aclk = 0;
    end

    // model state
    logic [QTY_W-1:0]  stock [NSLOT];
    logic [QTY_W-1:0]  taken [NSLOT];
    logic [AMT_W-1:0]  due_amt;
    logic [HOUR_W-1:0] hours;
    logic [AMT_W-1:0]  thresh;
    logic [HOUR_W-1:0] interval;

    res_t expected_results[$];
    logic [STAT_W-1:0] typed_stat[$];
    int errors = 0;
    int results_seen = 0;
    int items_sent = 0;
    int cycles = 0;
    int send_idle = 0;
    int recv_stall = 0;
    bit hold_off = 0;
    row_t rows[$];

    function automatic int denom(int s);
        int d[NSLOT] = '{10000, 5000, 2000, 1000, 500, 100, 25, 10, 5, 1};
        return (s < NSLOT) ? d[s] : 0;
    endfunction

    function automatic int start_qty(int s);
        int q[NSLOT] = '{0, 2, 2, 4, 2, 6, 6, 10, 10, 100};
        return (s < NSLOT) ? q[s] : 0;
    endfunction

    function automatic logic [QTY_W-1:0] sat_sum(int a, int b);
        return (a + b > 4095) ? 12'd4095 : 12'(a + b);
    endfunction

    function automatic void push_result(logic [STAT_W-1:0] st, int sl, int cnt, bit lst);
        longint t = 0;
        res_t r;
        for (int s = 0; s < NSLOT; s++) t += longint'(denom(s)) * stock[s];
        if (t > AMT_MAX) t = AMT_MAX;
        r.status = st;
        r.slot = sl[3:0];
        r.count = cnt[11:0];
        r.due = due_amt;
        r.bal = t[AMT_W-1:0];
        r.low = (t < thresh);
        r.last = lst;
        expected_results.push_back(r);
    endfunction

    // greedy trial from the largest slot down; true when exact
    function automatic bit greedy_fits(int amount);
        int rem = amount;
        int n;
        for (int s = 0; s < NSLOT; s++) begin
            n = rem / denom(s);
            if (n > stock[s]) n = stock[s];
            rem -= n * denom(s);
            taken[s] = n[11:0];
        end
        return rem == 0;
    endfunction

    // expected results of one accepted operation
    function automatic void predict_stock(op_t op);
        int n, k, used, was;
        int add[NSLOT];
        case (op.mode)
            MODE_ACCEPT: begin
                used = 0;
                if (op.first) due_amt = op.amt;
                if (op.slot < NSLOT) begin
                    used = due_amt / denom(op.slot);
                    if (used > op.qty) used = op.qty;
                    due_amt -= used * denom(op.slot);
                    stock[op.slot] = sat_sum(stock[op.slot], used);
                end
                push_result(ST_DONE, op.slot, used, 1);
            end
            MODE_DISPENSE: begin
                if (!greedy_fits(op.amt)) push_result(ST_CANNOT, 0, 0, 1);
                else begin
                    n = 0;
                    for (int s = 0; s < NSLOT; s++) begin
                        stock[s] -= taken[s];
                        if (taken[s] != 0) n++;
                    end
                    if (n == 0) push_result(ST_DONE, 0, 0, 1);
                    k = 0;
                    for (int s = 0; s < NSLOT; s++)
                        if (taken[s] != 0) begin
                            k++;
                            push_result(ST_ITEM, s, taken[s], k == n);
                        end
                end
            end
            MODE_CHECK: push_result(greedy_fits(op.amt) ? ST_CHECK_OK : ST_CANNOT, 0, 0, 1);
            MODE_ADD: begin
                used = 0;
                if (op.slot < NSLOT) begin
                    was = stock[op.slot];
                    stock[op.slot] = sat_sum(was, op.qty);
                    used = stock[op.slot] - was;
                end
                push_result(ST_DONE, op.slot, used, 1);
            end
            MODE_REFILL: begin
                if (hours < interval) push_result(ST_TOO_SOON, 0, 0, 1);
                else begin
                    n = 0;
                    for (int s = 0; s < NSLOT; s++) begin
                        add[s] = 0;
                        if (stock[s] < start_qty(s)) begin
                            add[s] = start_qty(s) - stock[s];
                            stock[s] = start_qty(s);
                            n++;
                        end
                    end
                    if (n == 0) push_result(ST_NO_REFILL, 0, 0, 1);
                    else begin
                        hours = 0;
                        k = 0;
                        for (int s = 0; s < NSLOT; s++)
                            if (add[s] != 0) begin
                                k++;
                                push_result(ST_ITEM, s, add[s], k == n);
                            end
                    end
                end
            end
            MODE_HOUR: begin
                if (hours < HOURS_MAX) hours++;
                push_result(ST_DONE, 0, 0, 1);
            end
            default: ;
        endcase
    endfunction

    // result checker
    always @(posedge aclk) begin
        res_t e;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result status %0d", $time, m_status);
                errors++;
            end else begin
                e = expected_results.pop_front();
                if (typed_stat.size() != 0 && e.last) begin
                    if (typed_stat[0] !== m_status) begin
                        $display("%0t: table status exp %0d got %0d",
                                 $time, typed_stat[0], m_status);
                        errors++;
                    end
                    void'(typed_stat.pop_front());
                end
                if ({m_status, m_slot_out, m_count_out, m_due_left, m_total_balance,
                     m_is_low, m_last} !== e) begin
                    $display("%0t: mismatch exp st=%0d sl=%0d cnt=%0d due=%0d bal=%0d low=%0d last=%0d",
                             $time, e.status, e.slot, e.count, e.due, e.bal, e.low, e.last);
                    $display("%0t:          got st=%0d sl=%0d cnt=%0d due=%0d bal=%0d low=%0d last=%0d",
                             $time, m_status, m_slot_out, m_count_out, m_due_left,
                             m_total_balance, m_is_low, m_last);
                    errors++;
                end
            end
        end
    end

    // receiver stall, with a long hold-off when asked
    int hold_cnt = 0;
    always @(posedge aclk) begin
        if (hold_off && hold_cnt < 400) begin
            hold_cnt <= hold_cnt + 1;
            m_ready <= 0;
        end else begin
            if (!hold_off) hold_cnt <= 0;
            m_ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    // timeout
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // valid drops only when the sender idles or the bus is drained
    task automatic send_op(op_t op);
        if ($urandom_range(99) < send_idle) begin
            s_valid <= 0;
            @(posedge aclk);
            while ($urandom_range(99) < send_idle) @(posedge aclk);
        end
        s_valid <= 1;
        {s_mode, s_slot, s_quantity, s_amount_cents, s_first} <= op;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_stock(op);
        items_sent++;
    endtask

    task automatic drain();
        s_valid <= 0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [AMT_W-1:0] val);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 0;
        @(posedge aclk);
        if (idx == CFG_LOW_THRESHOLD) thresh = val;
        else interval = val[HOUR_W-1:0];
    endtask

    function automatic op_t mk(logic [MODE_W-1:0] m, int sl, int q, int a, bit f);
        op_t o;
        o.mode = m;
        o.slot = sl[3:0];
        o.qty = q[11:0];
        o.amt = a[AMT_W-1:0];
        o.first = f;
        return o;
    endfunction

    function automatic void add_row(op_t o, bit h, logic [STAT_W-1:0] st);
        row_t r;
        r.op = o;
        r.has_stat = h;
        r.stat = st;
        rows.push_back(r);
    endfunction

    // one random session, a run of accepts or a single other operation, mostly sane
    task automatic random_session();
        int pick = $urandom_range(99);
        int a;
        if (pick < 35) begin
            a = $urandom_range(30000);
            for (int s = 0; s < NSLOT && $urandom_range(3) != 0; s += $urandom_range(1, 3))
                send_op(mk(MODE_ACCEPT, s, $urandom_range(5), a, s == 0));
        end else if (pick < 55)
            send_op(mk(MODE_DISPENSE, 0, 0, $urandom_range(1) ? $urandom_range(400)
                                              : $urandom_range(40000), 0));
        else if (pick < 65) send_op(mk(MODE_CHECK, 0, 0, $urandom_range(60000), 0));
        else if (pick < 75)
            send_op(mk(MODE_ADD, $urandom_range(15), $urandom_range(1) ? $urandom_range(20)
                                                    : $urandom_range(4095), 0, 0));
        else if (pick < 83) send_op(mk(MODE_REFILL, 0, 0, 0, 0));
        else if (pick < 93) send_op(mk(MODE_HOUR, 0, 0, 0, 0));
        else send_op(op_t'($bits(op_t)'({$urandom, $urandom})));
    endtask

    initial begin
        int idle_s[4] = '{0, 70, 0, 12};
        int idle_r[4] = '{0, 0, 70, 12};
        for (int s = 0; s < NSLOT; s++) stock[s] = start_qty(s);
        due_amt = 0;
        hours = HOURS_RESET;
        thresh = THRESH_RESET;
        interval = HOURS_RESET;
        repeat (3) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed table
        add_row(mk(MODE_REFILL, 0, 0, 0, 0), 1, ST_NO_REFILL);
        add_row(mk(MODE_CHECK, 0, 0, 0, 0), 1, ST_CHECK_OK);
        add_row(mk(MODE_DISPENSE, 0, 0, 0, 0), 1, ST_DONE);
        add_row(mk(MODE_DISPENSE, 0, 0, 34861, 0), 0, 0);
        add_row(mk(MODE_DISPENSE, 0, 0, 134217727, 0), 1, ST_CANNOT);
        add_row(mk(MODE_CHECK, 0, 0, 134217727, 0), 1, ST_CANNOT);
        add_row(mk(MODE_ACCEPT, 0, 4095, 134217727, 1), 1, ST_DONE);
        add_row(mk(MODE_ACCEPT, 9, 4095, 0, 0), 1, ST_DONE);
        add_row(mk(MODE_ACCEPT, 15, 7, 0, 0), 1, ST_DONE);
        add_row(mk(MODE_ACCEPT, 3, 0, 5000, 1), 1, ST_DONE);
        add_row(mk(MODE_ADD, 9, 4095, 0, 0), 1, ST_DONE);
        add_row(mk(MODE_ADD, 12, 3, 0, 0), 1, ST_DONE);
        add_row(mk(MODE_ADD, 0, 0, 0, 0), 1, ST_DONE);
        add_row(mk(MODE_DISPENSE, 0, 0, 12345, 0), 0, 0);
        add_row(mk(MODE_REFILL, 0, 0, 0, 0), 0, 0);
        add_row(mk(MODE_REFILL, 0, 0, 0, 0), 1, ST_TOO_SOON);
        add_row(mk(3'd6, 0, 0, 0, 0), 0, 0);
        add_row(mk(3'd7, 15, 4095, 134217727, 1), 0, 0);
        for (int i = 0; i < 33; i++) add_row(mk(MODE_HOUR, 0, 0, 0, 0), 1, ST_DONE);
        add_row(mk(MODE_DISPENSE, 0, 0, 5, 0), 0, 0);
        add_row(mk(MODE_REFILL, 0, 0, 0, 0), 0, 0);
        foreach (rows[i]) begin
            if (rows[i].has_stat) begin
                drain();
                typed_stat.push_back(rows[i].stat);
            end
            send_op(rows[i].op);
            if (rows[i].has_stat) drain();
        end
        drain();

        // random phases across register settings and idle patterns
        for (int ph = 0; ph < 4; ph++) begin
            write_reg(CFG_LOW_THRESHOLD,
                      AMT_W'(ph == 0 ? 0 : ph == 1 ? 76334895 : $urandom_range(80000)));
            write_reg(CFG_REFILL_INTERVAL,
                      AMT_W'(ph == 0 ? 1 : ph == 1 ? 31 : $urandom_range(1, 31)));
            send_idle = idle_s[ph];
            recv_stall = idle_r[ph];
            for (int i = 0; i < 44; i++) random_session();
            if (ph == 0) begin
                hold_off = 1;
                for (int i = 0; i < 6; i++) send_op(mk(MODE_HOUR, 0, 0, 0, 0));
                hold_off = 0;
            end
            drain();
        end

        $display("sent %0d items, checked %0d results over 4 idle phases and 4 settings",
                 items_sent, results_seen);
        if (errors == 0) $display("CHECK OK");
        else $display("CHECK FAILED");
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+design
design/csd_pkg.sv
design/csd_qsearch.sv
design/change_stock_dispenser.sv
test/testbench.sv
